### hw/rtl/sda_pkg.sv
// Package with types, constants and helpers for the stable descending argsort.
`timescale 1ns / 1ps
`default_nettype none

package sda_pkg;

    localparam int MAX_MEMBERS  = 64;
    localparam int FITNESS_BITS = 32;
    localparam int FIT_IN_W     = 32;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = $clog2(MAX_MEMBERS + 1);

    localparam logic signed [63:0] FIT_MAX = (64'sd1 <<< (FITNESS_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] FIT_MIN = -FIT_MAX - 64'sd1;

    typedef struct packed {
        logic signed [FIT_IN_W-1:0] fitness;
        logic                       last;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] member_index;
        logic             final_res;
    } rank_t;

    typedef struct packed {
        logic signed [FITNESS_BITS-1:0] fitness;
        logic [IDX_W-1:0]               member;
    } cell_t;

    // Clamp the incoming fitness to the stored width.
    function automatic logic signed [FITNESS_BITS-1:0] fit_sat(
        input logic signed [FIT_IN_W-1:0] raw
    );
        logic signed [63:0] wide;
        wide = {{(64 - FIT_IN_W){raw[FIT_IN_W-1]}}, raw};
        if (wide > FIT_MAX) begin
            wide = FIT_MAX;
        end
        else if (wide < FIT_MIN) begin
            wide = FIT_MIN;
        end
        return wide[FITNESS_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/stable_descending_argsort.sv
// Top level of the stable descending argsort over a population of fitness values.
//
// Usage:
//   item channel (item_valid/item_ready/item_data) carries one member's fitness
//   per transaction; arrival order since the last ranking is the member index.
//   A transaction with last set closes the population; the block then sends the
//   member indices best first on the rank channel (rank_valid/rank_ready/
//   rank_data), with final_res set on the last one. Equal fitness values come
//   out in ascending index order. Items past MAX_MEMBERS are dropped, but their
//   last mark still starts the ranking.
// Timing:
//   The ordered list lives in one memory with one write and one read port.
//   Inserting into a list of n members scans it from the tail, one entry per
//   cycle; the first or a dropped item needs no scan. item_ready is low during
//   the scan and ranking output. After the last item, the first rank passes the
//   memory read and output registers, then one per cycle unless rank_ready stalls.
// Reset and stalls:
//   Reset empties the list (the member count goes to zero; memory is not swept).
//   A stalled rank transaction holds in the output register and pauses the
//   memory walk; a finished final rank may wait while new items are taken.
`timescale 1ns / 1ps
`default_nettype none

module stable_descending_argsort
    import sda_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item_data,
    output logic       rank_valid,
    input  wire logic  rank_ready,
    output rank_t      rank_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    cell_t mem [MAX_MEMBERS];
    cell_t rd_data_reg;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] d_reg, d_next;
    logic signed [FITNESS_BITS-1:0] f_reg, f_next;
    logic             last_reg, last_next;
    logic             rank_valid_reg, rank_valid_next;
    rank_t            rank_reg, rank_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    cell_t            wr_data;
    logic             rank_load;
    logic             finish;
    logic             fin_last;
    logic             is_final;
    logic signed [FITNESS_BITS-1:0] fit_in;

    assign fit_in     = fit_sat(item_data.fitness);
    assign item_ready = (state_reg == S_IDLE);
    assign rank_valid = rank_valid_reg;
    assign rank_data  = rank_reg;
    assign is_final   = ((CNT_W'(d_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        f_next     = f_reg;
        last_next  = last_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rank_load  = 1'b0;
        rank_next  = rank_reg;
        finish     = 1'b0;
        fin_last   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (count_reg == CNT_W'(MAX_MEMBERS))
                    begin
                        // drop the item, keep its last mark
                        finish   = 1'b1;
                        fin_last = item_data.last;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = '{fitness: fit_in, member: '0};
                        count_next = CNT_W'(1);
                        finish     = 1'b1;
                        fin_last   = item_data.last;
                    end
                    else
                    begin
                        f_next     = fit_in;
                        last_next  = item_data.last;
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(count_reg - CNT_W'(1));
                        k_next     = IDX_W'(count_reg - CNT_W'(1));
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg + IDX_W'(1);
                if ($signed(rd_data_reg.fitness) >= $signed(f_reg))
                begin
                    // stop behind the last entry that ranks at or above
                    wr_data    = '{fitness: f_reg, member: count_reg[IDX_W-1:0]};
                    count_next = count_reg + CNT_W'(1);
                    finish     = 1'b1;
                    fin_last   = last_reg;
                end
                else
                begin
                    wr_data = rd_data_reg;
                    if (k_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = k_reg - IDX_W'(1);
                        k_next  = k_reg - IDX_W'(1);
                    end
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{fitness: f_reg, member: count_reg[IDX_W-1:0]};
                count_next = count_reg + CNT_W'(1);
                finish     = 1'b1;
                fin_last   = last_reg;
            end
            S_DRAIN:
            begin
                if (!rank_valid_reg || rank_ready)
                begin
                    rank_load = 1'b1;
                    rank_next = '{member_index: rd_data_reg.member, final_res: is_final};
                    if (is_final)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = d_reg + IDX_W'(1);
                        d_next  = d_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (fin_last)
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                d_next     = '0;
                state_next = S_DRAIN;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_comb
    begin
        if (rank_load)
        begin
            rank_valid_next = 1'b1;
        end
        else if (rank_ready)
        begin
            rank_valid_next = 1'b0;
        end
        else
        begin
            rank_valid_next = rank_valid_reg;
        end
    end

    // List memory; forward a write to a read of the same entry in that cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rank_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rank_valid_reg <= rank_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        d_reg    <= d_next;
        f_reg    <= f_next;
        last_reg <= last_next;
        rank_reg <= rank_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_MEMBERS))
        else $error("member count beyond capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(k_reg) < count_reg))
        else $error("scan index outside loaded list");

    a_final_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (rank_load && rank_next.final_res) |=> (count_reg == '0 && state_reg == S_IDLE))
        else $error("list not emptied after final rank");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && !item_data.last && count_reg == CNT_W'(MAX_MEMBERS))
        |=> (count_reg == CNT_W'(MAX_MEMBERS) && state_reg == S_IDLE))
        else $error("item stored into a full list");

endmodule

`default_nettype wire
